>>> rtl/core/circle_segment_cross_test_core_assert.svh
// Assertion macros shared by the circle and segment test core.
`ifndef CIRCLE_SEGMENT_CROSS_TEST_CORE_ASSERT_SVH
`define CIRCLE_SEGMENT_CROSS_TEST_CORE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, silent while i_rst_n is low.
`define CSCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csct: same-cycle check failed");

// Next-cycle implication, clocked on i_clk, silent while i_rst_n is low.
`define CSCT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csct: next-cycle check failed");

`endif

>>> rtl/core/csct_pkg.sv
// Widths, register indexes and control types of the circle and segment test core.
`default_nettype none

package csct_pkg;

    // coordinate width of every field and register
    localparam int CW    = 16;
    // signed difference of two coordinates
    localparam int DW    = CW + 1;
    // square of a difference, unsigned
    localparam int SQW   = 2 * CW + 1;
    // sum of two squares, unsigned; also magnitudes fed to the final compare
    localparam int LW    = SQW + 1;
    // signed power and dot product
    localparam int PW    = LW + 1;
    // half split of the second multiplier operand
    localparam int HW    = LW / 2;
    // full product width of the final compare
    localparam int QW    = 2 * LW;

    // stream word widths
    localparam int IN_W  = ((4 * CW + 7) / 8) * 8;
    localparam int OUT_W = 8;

    // configuration register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_CENTRE_X = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_CENTRE_Y = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RADIUS   = 2'd2;

    // outcome of the classification stage
    typedef struct packed {
        logic need;   // answer comes from the discriminant compare
        logic early;  // answer when no compare is needed
    } t_ctl;

endpackage

`default_nettype wire

>>> rtl/core/circle_segment_cross_test_core.sv
// Top level of the circle and segment boundary test: config, front pipeline, output.
//
// Usage:
//   Write the circle through the configuration channel (i_cfg_valid/o_cfg_ready,
//   i_cfg_index, i_cfg_data): index 0 centre x, 1 centre y, 2 radius; any other
//   index is dropped. o_cfg_ready is always high. Write only while the core is idle.
//   Send one segment per word on the slave stream (start_x, start_y, end_x, end_y,
//   16 bits each). Each accepted word yields exactly one result word on the master
//   stream, bit 0 set when the segment meets the circle boundary.
//   Throughput: one word per cycle while the receiver takes results; seven register
//   stages, each with one multiplier level or one wide add and compare, set that figure.
//   Reset (i_rst_n low, synchronous) clears the circle to zero and empties every
//   stage; no clearing pass is needed.
//   When the receiver stalls, the result word holds in the output register and
//   the stages behind it keep filling their bubbles; input is refused only once
//   every stage is occupied.
`default_nettype none

`include "circle_segment_cross_test_core_assert.svh"

module circle_segment_cross_test_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write channel
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [csct_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [csct_pkg::CW-1:0]    i_cfg_data,
    // segment stream
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata from bit 0: start_x, start_y, end_x, end_y
    input  wire logic [csct_pkg::IN_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // tdata from bit 0: crosses, then zero fill
    output logic [csct_pkg::OUT_W-1:0]      o_m_axis_tdata
);
    import csct_pkg::*;

    // circle registers
    logic [CW-1:0] r_centre_x, r_centre_y, r_radius;

    // stage valids and advance chain
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic w_adv1, w_adv2, w_adv3, w_adv4;
    logic w_cmp_ready, w_cmp_valid, w_crosses;

    // input fields
    logic signed [CW-1:0] w_sx, w_sy, w_ex, w_ey;

    // stage 1: differences
    logic signed [DW-1:0] r_s1_ax, r_s1_ay, r_s1_bx, r_s1_by, r_s1_ux, r_s1_uy;

    // stage 2: products
    logic signed [2*DW-1:0] w_ax2, w_ay2, w_bx2, w_by2, w_ux2, w_uy2;
    logic [SQW-1:0]         r_s2_ax2, r_s2_ay2, r_s2_bx2, r_s2_by2, r_s2_ux2, r_s2_uy2;
    logic signed [2*DW-1:0] r_s2_uxax, r_s2_uyay;
    logic [2*CW-1:0]        r_s2_r2;

    // stage 3: powers, length and dot product
    logic [LW-1:0]        w_aa, w_bb;
    logic signed [PW-1:0] r_s3_pa, r_s3_pb, r_s3_d;
    logic [LW-1:0]        r_s3_len;

    // stage 4: classification and magnitudes
    logic signed [PW:0]   w_sum_dl;
    logic signed [PW-1:0] w_neg_d;
    logic                 w_pa_neg, w_pa_pos, w_pb_neg, w_pb_pos;
    t_ctl                 n_ctl, r_s4_ctl;
    logic [LW-1:0]        r_s4_md, r_s4_len, r_s4_pa;

    // ---------------------------------------------------------------
    // Configuration: always ready, unknown indexes dropped
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_radius   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTRE_X: r_centre_x <= i_cfg_data;
                CFG_CENTRE_Y: r_centre_y <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Advance chain: a stage loads when it is empty or its word moves on
    // ---------------------------------------------------------------
    assign w_adv4 = !r_s4_vld || w_cmp_ready;
    assign w_adv3 = !r_s3_vld || w_adv4;
    assign w_adv2 = !r_s2_vld || w_adv3;
    assign w_adv1 = !r_s1_vld || w_adv2;
    assign o_s_axis_tready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (w_adv1) r_s1_vld <= i_s_axis_tvalid;
            if (w_adv2) r_s2_vld <= r_s1_vld;
            if (w_adv3) r_s3_vld <= r_s2_vld;
            if (w_adv4) r_s4_vld <= r_s3_vld;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: offsets from the centre and the segment direction
    // ---------------------------------------------------------------
    assign w_sx = i_s_axis_tdata[CW-1:0];
    assign w_sy = i_s_axis_tdata[2*CW-1:CW];
    assign w_ex = i_s_axis_tdata[3*CW-1:2*CW];
    assign w_ey = i_s_axis_tdata[4*CW-1:3*CW];

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_ax <= $signed({w_sx[CW-1], w_sx}) - $signed({r_centre_x[CW-1], r_centre_x});
            r_s1_ay <= $signed({w_sy[CW-1], w_sy}) - $signed({r_centre_y[CW-1], r_centre_y});
            r_s1_bx <= $signed({w_ex[CW-1], w_ex}) - $signed({r_centre_x[CW-1], r_centre_x});
            r_s1_by <= $signed({w_ey[CW-1], w_ey}) - $signed({r_centre_y[CW-1], r_centre_y});
            r_s1_ux <= $signed({w_ex[CW-1], w_ex}) - $signed({w_sx[CW-1], w_sx});
            r_s1_uy <= $signed({w_ey[CW-1], w_ey}) - $signed({w_sy[CW-1], w_sy});
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: one level of narrow multipliers
    // ---------------------------------------------------------------
    assign w_ax2 = r_s1_ax * r_s1_ax;
    assign w_ay2 = r_s1_ay * r_s1_ay;
    assign w_bx2 = r_s1_bx * r_s1_bx;
    assign w_by2 = r_s1_by * r_s1_by;
    assign w_ux2 = r_s1_ux * r_s1_ux;
    assign w_uy2 = r_s1_uy * r_s1_uy;

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            // squares are never negative: drop the sign bit
            r_s2_ax2  <= w_ax2[SQW-1:0];
            r_s2_ay2  <= w_ay2[SQW-1:0];
            r_s2_bx2  <= w_bx2[SQW-1:0];
            r_s2_by2  <= w_by2[SQW-1:0];
            r_s2_ux2  <= w_ux2[SQW-1:0];
            r_s2_uy2  <= w_uy2[SQW-1:0];
            r_s2_uxax <= r_s1_ux * r_s1_ax;
            r_s2_uyay <= r_s1_uy * r_s1_ay;
            r_s2_r2   <= r_radius * r_radius;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: endpoint powers, squared length, direction dot offset
    // ---------------------------------------------------------------
    assign w_aa = {1'b0, r_s2_ax2} + {1'b0, r_s2_ay2};
    assign w_bb = {1'b0, r_s2_bx2} + {1'b0, r_s2_by2};

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_s3_pa  <= $signed({1'b0, w_aa}) - $signed({{(PW-2*CW){1'b0}}, r_s2_r2});
            r_s3_pb  <= $signed({1'b0, w_bb}) - $signed({{(PW-2*CW){1'b0}}, r_s2_r2});
            r_s3_len <= {1'b0, r_s2_ux2} + {1'b0, r_s2_uy2};
            r_s3_d   <= $signed({{(PW-2*DW){r_s2_uxax[2*DW-1]}}, r_s2_uxax})
                      + $signed({{(PW-2*DW){r_s2_uyay[2*DW-1]}}, r_s2_uyay});
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: classify; only the both-outside case with the nearest point
    // inside the segment needs the discriminant
    // ---------------------------------------------------------------
    assign w_pa_neg = r_s3_pa[PW-1];
    assign w_pa_pos = !r_s3_pa[PW-1] && (r_s3_pa != '0);
    assign w_pb_neg = r_s3_pb[PW-1];
    assign w_pb_pos = !r_s3_pb[PW-1] && (r_s3_pb != '0);
    assign w_sum_dl = $signed({r_s3_d[PW-1], r_s3_d}) + $signed({2'b00, r_s3_len});
    assign w_neg_d  = -r_s3_d;

    always_comb begin
        n_ctl = '0;
        if (w_pa_neg && w_pb_neg) begin
            // both strictly inside
            n_ctl.early = 1'b0;
        end else if (!(w_pa_pos && w_pb_pos)) begin
            // one endpoint on or inside, the other on or outside
            n_ctl.early = 1'b1;
        end else if ((r_s3_len == '0) || (!r_s3_d[PW-1] && (r_s3_d != '0))
                     || w_sum_dl[PW]) begin
            // degenerate segment, or nearest point beyond an endpoint
            n_ctl.early = 1'b0;
        end else begin
            n_ctl.need = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_s4_ctl <= n_ctl;
            r_s4_md  <= w_neg_d[LW-1:0];
            r_s4_len <= r_s3_len;
            r_s4_pa  <= r_s3_pa[LW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stages 5 to 7: discriminant compare and output register
    // ---------------------------------------------------------------
    csct_disc_cmp u_disc_cmp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s4_vld),
        .o_ready   (w_cmp_ready),
        .i_ctl     (r_s4_ctl),
        .i_mag_d   (r_s4_md),
        .i_len     (r_s4_len),
        .i_pa      (r_s4_pa),
        .o_valid   (w_cmp_valid),
        .i_ready   (i_m_axis_tready),
        .o_crosses (w_crosses)
    );

    assign o_m_axis_tvalid = w_cmp_valid;
    assign o_m_axis_tdata  = {{(OUT_W-1){1'b0}}, w_crosses};

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // an empty output register lets the whole pipeline advance
    `CSCT_ASSERT_IMP(a_ready_when_out_empty, !o_m_axis_tvalid, o_s_axis_tready)
    // an accepted word always lands in stage 1
    `CSCT_ASSERT_NXT(a_accept_lands, i_s_axis_tvalid && o_s_axis_tready, r_s1_vld)
    // compare operands are in range whenever the discriminant is used
    `CSCT_ASSERT_IMP(a_need_operands, r_s4_vld && r_s4_ctl.need,
                     (r_s4_len != '0) && (r_s4_md <= r_s4_len) && (r_s4_pa != '0))

endmodule

`default_nettype wire

>>> rtl/core/csct_disc_cmp.sv
// Pipelined exact compare d*d >= len*pa, three stages, last stage is the output register.
`default_nettype none

module csct_disc_cmp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire csct_pkg::t_ctl        i_ctl,
    input  wire logic [csct_pkg::LW-1:0] i_mag_d,
    input  wire logic [csct_pkg::LW-1:0] i_len,
    input  wire logic [csct_pkg::LW-1:0] i_pa,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_crosses
);
    import csct_pkg::*;

    logic               r_s5_vld, r_s6_vld, r_s7_vld;
    logic               w_adv5, w_adv6, w_adv7;
    t_ctl               r_s5_ctl, r_s6_ctl;
    logic [LW+HW-1:0]   r_s5_dd_lo, r_s5_dd_hi, r_s5_lp_lo, r_s5_lp_hi;
    logic [QW-1:0]      r_s6_dd, r_s6_lp;
    logic               r_s7_crosses;
    logic               n_crosses;

    assign w_adv7  = !r_s7_vld || i_ready;
    assign w_adv6  = !r_s6_vld || w_adv7;
    assign w_adv5  = !r_s5_vld || w_adv6;
    assign o_ready = w_adv5;

    assign n_crosses = r_s6_ctl.need ? (r_s6_dd >= r_s6_lp) : r_s6_ctl.early;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else begin
            if (w_adv5) r_s5_vld <= i_valid;
            if (w_adv6) r_s6_vld <= r_s5_vld;
            if (w_adv7) r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv5) begin
            // split the second operand so each multiplier stays narrow
            r_s5_ctl   <= i_ctl;
            r_s5_dd_lo <= i_mag_d * {{(LW-HW){1'b0}}, i_mag_d[HW-1:0]};
            r_s5_dd_hi <= i_mag_d * i_mag_d[LW-1:HW];
            r_s5_lp_lo <= i_len * {{(LW-HW){1'b0}}, i_pa[HW-1:0]};
            r_s5_lp_hi <= i_len * i_pa[LW-1:HW];
        end
        if (w_adv6) begin
            r_s6_ctl <= r_s5_ctl;
            r_s6_dd  <= {{(QW-LW-HW){1'b0}}, r_s5_dd_lo}
                      + {r_s5_dd_hi[QW-HW-1:0], {HW{1'b0}}};
            r_s6_lp  <= {{(QW-LW-HW){1'b0}}, r_s5_lp_lo}
                      + {r_s5_lp_hi[QW-HW-1:0], {HW{1'b0}}};
        end
        if (w_adv7) begin
            r_s7_crosses <= n_crosses;
        end
    end

    assign o_valid   = r_s7_vld;
    assign o_crosses = r_s7_crosses;

endmodule

`default_nettype wire
